// File: rtl/value_noise_2d_bilinear_assert.svh
// Assertion macros for the value noise RTL.
`ifndef VALUE_NOISE_2D_BILINEAR_ASSERT_SVH
`define VALUE_NOISE_2D_BILINEAR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vn2d_pkg.sv
`default_nettype none
package vn2d_pkg;
  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned OutFracBits   = 14;
  localparam int unsigned CornerFrac    = 30;
  localparam int unsigned CellW         = 13;
  localparam int unsigned NumStages     = 10;

  localparam logic [31:0] HashY    = 32'd321;
  localparam logic [31:0] HashSeed = 32'd1327;
  localparam logic [31:0] HashMulA = 32'd15731;
  localparam logic [31:0] HashAddA = 32'd789221;
  localparam logic [31:0] HashAddB = 32'd1376312589;
  localparam logic [31:0] HashMask = 32'h7fffffff;
  localparam logic [31:0] CornerOne = 32'h40000000;

  typedef enum logic [7:0] {
    RegCellCount = 8'd0,
    RegNoiseSeed = 8'd1
  } reg_idx_e;

  typedef logic [31:0] word_t;
endpackage
`default_nettype wire

// File: rtl/value_noise_2d_bilinear.sv
`default_nettype none
// Tiling 2D value noise. Each input transaction carries a point inside one tile
// as unsigned Q0.16 fractions; the block returns one signed Q1.14 noise value in
// [-1, 1] per point, in order. Points are scaled by cell_count into a lattice
// cell and in-cell fraction, the four surrounding lattice corners are hashed
// with the seeded 32-bit integer hash, and the corners are blended bilinearly.
// The datapath is a ten-stage pipeline: a new point may enter every clock while
// stall_o is low. Each stage holds its own valid bit, so a stalled output only
// backs up stages that are full; bubbles are squeezed out.
// Configuration (cell_count at index 0, noise_seed at index 1) is taken any
// cycle and must only change while the pipeline is empty; writes to other
// indexes are ignored.
module value_noise_2d_bilinear (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [7:0]                      cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire logic                            valid_i,
  output logic                                 stall_o,
  input  wire logic [15:0]                     x_frac_i,
  input  wire logic [15:0]                     y_frac_i,
  output logic                                 valid_o,
  input  wire logic                            stall_i,
  output logic signed [15:0]                   noise_value_o
);
  import vn2d_pkg::*;

  localparam int unsigned Shift = CornerFrac + CoordFracBits - OutFracBits;

  // Configuration. The seed is kept premultiplied by its hash constant.
  logic [CellW-1:0] cells_q;
  word_t            seed_mul_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q    <= CellW'(1);
      seed_mul_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegCellCount) begin
        // A count of zero behaves as one cell.
        cells_q <= (cfg_data_i[CellW-1:0] == '0) ? CellW'(1) : cfg_data_i[CellW-1:0];
      end else if (cfg_index_i == RegNoiseSeed) begin
        seed_mul_q <= cfg_data_i * HashSeed;
      end
    end
  end

  // Per-stage valid bits and load enables. A stage loads when it is empty or
  // when the stage after it moves on.
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 0: split each coordinate into cell index and fraction.
  logic [CellW+15:0]        px, py;
  logic [CellW-1:0]         ix0_q, iy0_q;
  logic [CoordFracBits-1:0] fx_q [0:5];
  logic [CoordFracBits-1:0] fy_q [0:7];

  assign px = (CellW+16)'(x_frac_i[CoordFracBits-1:0]) * (CellW+16)'(cells_q);
  assign py = (CellW+16)'(y_frac_i[CoordFracBits-1:0]) * (CellW+16)'(cells_q);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ix0_q   <= px[CoordFracBits +: CellW];
      iy0_q   <= py[CoordFracBits +: CellW];
      fx_q[0] <= px[CoordFracBits-1:0];
      fy_q[0] <= py[CoordFracBits-1:0];
    end
    for (int k = 1; k <= 5; k++) begin
      if (en[k]) fx_q[k] <= fx_q[k-1];
    end
    for (int k = 1; k <= 7; k++) begin
      if (en[k]) fy_q[k] <= fy_q[k-1];
    end
  end

  // Stage 1: neighbour indices (wrapping at the cell count) and hash input.
  // Lanes: 0 = (x1,y1), 1 = (x2,y1), 2 = (x1,y2), 3 = (x2,y2).
  logic [CellW:0]   ix_inc, iy_inc;
  logic [CellW-1:0] ix_nxt, iy_nxt;
  word_t            lx [0:3];
  word_t            ly [0:3];
  word_t            n1_q [0:3];

  assign ix_inc = {1'b0, ix0_q} + 1'b1;
  assign iy_inc = {1'b0, iy0_q} + 1'b1;
  assign ix_nxt = (ix_inc == {1'b0, cells_q}) ? '0 : ix_inc[CellW-1:0];
  assign iy_nxt = (iy_inc == {1'b0, cells_q}) ? '0 : iy_inc[CellW-1:0];

  always_comb begin
    lx[0] = 32'(ix0_q);  ly[0] = 32'(iy0_q);
    lx[1] = 32'(ix_nxt); ly[1] = 32'(iy0_q);
    lx[2] = 32'(ix0_q);  ly[2] = 32'(iy_nxt);
    lx[3] = 32'(ix_nxt); ly[3] = 32'(iy_nxt);
  end

  // Hash lanes, stages 1 through 5.
  word_t n2_q [0:3];
  word_t nn_q [0:3];
  word_t n3_q [0:3];
  word_t m_q  [0:3];
  word_t t_q  [0:3];
  logic signed [31:0] corner_q [0:3];
  word_t n_xs [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      n_xs[l] = n1_q[l] ^ (n1_q[l] << 13);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      if (en[1]) n1_q[l] <= lx[l] + ly[l] * HashY + seed_mul_q;
      if (en[2]) begin
        n2_q[l] <= n_xs[l];
        nn_q[l] <= n_xs[l] * n_xs[l];
      end
      if (en[3]) begin
        n3_q[l] <= n2_q[l];
        m_q[l]  <= nn_q[l] * HashMulA + HashAddA;
      end
      if (en[4]) t_q[l] <= n3_q[l] * m_q[l];
      if (en[5]) corner_q[l] <= $signed(CornerOne - ((t_q[l] + HashAddB) & HashMask));
    end
  end

  // Stages 6 and 7: horizontal blend, rounded back to Q1.30.
  logic signed [17:0] wx0, wx1, wy0, wy1;
  logic signed [49:0] hp_q [0:3];
  logic signed [50:0] hs0, hs1;
  logic signed [31:0] k1_q, k2_q;

  assign wx0 = $signed({1'b0, 17'((18'd1 << CoordFracBits) - 18'(fx_q[5]))});
  assign wx1 = $signed({2'b00, fx_q[5]});
  assign wy0 = $signed({1'b0, 17'((18'd1 << CoordFracBits) - 18'(fy_q[7]))});
  assign wy1 = $signed({2'b00, fy_q[7]});

  assign hs0 = 51'(hp_q[0]) + 51'(hp_q[1]) + (51'sd1 <<< (CoordFracBits - 1));
  assign hs1 = 51'(hp_q[2]) + 51'(hp_q[3]) + (51'sd1 <<< (CoordFracBits - 1));

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      hp_q[0] <= 50'(corner_q[0]) * 50'(wx0);
      hp_q[1] <= 50'(corner_q[1]) * 50'(wx1);
      hp_q[2] <= 50'(corner_q[2]) * 50'(wx0);
      hp_q[3] <= 50'(corner_q[3]) * 50'(wx1);
    end
    if (en[7]) begin
      k1_q <= 32'(hs0 >>> CoordFracBits);
      k2_q <= 32'(hs1 >>> CoordFracBits);
    end
  end

  // Stages 8 and 9: vertical blend, then round half up, clamp and register.
  logic signed [49:0] vp0_q, vp1_q;
  logic signed [50:0] vs;
  logic signed [50:0] vsh;
  logic signed [15:0] res;
  logic signed [15:0] out_q;

  assign vs  = 51'(vp0_q) + 51'(vp1_q) + (51'sd1 <<< (Shift - 1));
  assign vsh = vs >>> Shift;

  always_comb begin
    if (vsh > (51'sd1 <<< OutFracBits)) begin
      res = 16'sd1 <<< OutFracBits;
    end else if (vsh < -(51'sd1 <<< OutFracBits)) begin
      res = -(16'sd1 <<< OutFracBits);
    end else begin
      res = 16'(vsh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      vp0_q <= 50'(k1_q) * 50'(wy0);
      vp1_q <= 50'(k2_q) * 50'(wy1);
    end
    if (en[9]) out_q <= res;
  end

  assign valid_o       = v_q[NumStages-1];
  assign noise_value_o = out_q;

  `include "value_noise_2d_bilinear_assert.svh"

  // Results never leave the Q1.14 range of minus one to one.
  `VN_ASSERT_NOW(a_out_range, valid_o,
    (noise_value_o <= 16'sd16384) && (noise_value_o >= -16'sd16384),
    "noise value out of range")
  // With no result waiting the pipeline must never push back on its input.
  `VN_ASSERT_NOW(a_no_stall_empty, !valid_o, !stall_o, "stall while output empty")
  // An accepted transaction occupies the first stage on the next cycle.
  `VN_ASSERT_NEXT(a_enter, valid_i && !stall_o, v_q[0], "accepted item lost at entry")

endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;
  import vn2d_pkg::*;

  // Point coordinates of one input transaction.
  typedef struct packed {
    logic [15:0] x_frac;
    logic [15:0] y_frac;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [15:0] x_frac_i = '0;
  logic [15:0] y_frac_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [15:0] noise_value_o;

  value_noise_2d_bilinear uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .valid_i, .stall_o, .x_frac_i, .y_frac_i, .valid_o, .stall_i, .noise_value_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: our own copy of the two registers.
  logic [12:0] model_cells = 13'd1;
  logic [31:0] model_seed = '0;

  point_t pending_points[$];
  logic signed [15:0] expected_noise[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit feed_enable = 1'b0;
  int unsigned long_holdoff = 0;

  // Seeded lattice hash, returned as an exact Q1.30 corner value.
  function automatic longint corner_value(logic [31:0] xi, logic [31:0] yi);
    logic [31:0] n;
    logic [31:0] t;
    begin
      n = xi + yi * HashY + model_seed * HashSeed;
      n = (n << 13) ^ n;
      t = (n * (n * n * HashMulA + HashAddA) + HashAddB) & HashMask;
      return longint'(CornerOne) - longint'({32'd0, t});
    end
  endfunction

  // Arithmetic shift right floors, matching the rounding of the datapath.
  function automatic logic signed [15:0] predict_noise(point_t p);
    longint cells, px, py, fx, fy, one, k1, k2, v;
    logic [31:0] x1, x2, y1, y2;
    begin
      cells = (model_cells == 0) ? 1 : model_cells;
      one = 64'sd1 << CoordFracBits;
      px = longint'(p.x_frac) * cells;
      py = longint'(p.y_frac) * cells;
      x1 = 32'(px >>> CoordFracBits);
      y1 = 32'(py >>> CoordFracBits);
      fx = px & (one - 1);
      fy = py & (one - 1);
      x2 = (longint'(x1) + 1 == cells) ? 32'd0 : x1 + 1;
      y2 = (longint'(y1) + 1 == cells) ? 32'd0 : y1 + 1;
      k1 = (corner_value(x1, y1) * (one - fx) + corner_value(x2, y1) * fx
            + (one >>> 1)) >>> CoordFracBits;
      k2 = (corner_value(x1, y2) * (one - fx) + corner_value(x2, y2) * fx
            + (one >>> 1)) >>> CoordFracBits;
      v = k1 * (one - fy) + k2 * fy;
      v = (v + (64'sd1 << (CornerFrac + CoordFracBits - OutFracBits - 1)))
          >>> (CornerFrac + CoordFracBits - OutFracBits);
      if (v > (64'sd1 << OutFracBits)) v = 64'sd1 << OutFracBits;
      if (v < -(64'sd1 << OutFracBits)) v = -(64'sd1 << OutFracBits);
      return 16'(v);
    end
  endfunction

  // The driver sends points in bursts with random gaps. A point that is held
  // by stall keeps its payload; valid never looks at stall.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      expected_noise.push_back(predict_noise('{x_frac: x_frac_i, y_frac: y_frac_i}));
    end
    if (!(valid_i && stall_o)) begin
      if (feed_enable && pending_points.size() > 0 && gap_left == 0) begin
        point_t p;
        p = pending_points.pop_front();
        valid_i <= 1'b1;
        x_frac_i <= p.x_frac;
        y_frac_i <= p.y_frac;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        valid_i <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end
    end
  end

  // The receiver stalls on its own pattern, with an occasional long hold-off.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (long_holdoff > 0) begin
      long_holdoff <= long_holdoff - 1;
      stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: stall_i <= 1'b0;
        1: stall_i <= ($urandom_range(0, 3) == 0);
        default: stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // The monitor compares each result with the oldest prediction.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_noise.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result noise_value=%0d", noise_value_o);
      end else begin
        logic signed [15:0] want;
        want = expected_noise.pop_front();
        if (want !== noise_value_o) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("noise_value mismatch: expected %0d actual %0d", want, noise_value_o);
        end
      end
    end
  end

  // Watchdog for a hung pipeline.
  always @(posedge clk_i) begin
    if (cycle_count > 2000000) begin
      $display("** value_noise_2d_bilinear: FAILED **");
      $finish;
    end
  end

  // One register write over the configuration channel, idle pipeline only.
  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    begin
      @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_valid_i <= 1'b0;
      if (idx == RegCellCount) model_cells = data[12:0];
      else model_seed = data;
    end
  endtask

  // Waits until all queued points were sent and every result came back, then
  // lets the pipeline settle before returning.
  task automatic drain;
    begin
      while (pending_points.size() > 0 || valid_i || expected_noise.size() > 0)
        @(posedge clk_i);
      repeat (NumStages + 5) @(posedge clk_i);
    end
  endtask

  task automatic add_point(logic [15:0] xf, logic [15:0] yf);
    pending_points.push_back('{x_frac: xf, y_frac: yf});
  endtask

  // Random points: mostly uniform, some near the cell edges of the lattice.
  task automatic add_random(int count);
    logic [15:0] xf, yf;
    begin
      for (int i = 0; i < count; i++) begin
        xf = 16'($urandom);
        yf = 16'($urandom);
        if ($urandom_range(0, 7) == 0) xf = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        if ($urandom_range(0, 7) == 0) yf = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        add_point(xf, yf);
      end
    end
  endtask

  initial begin
    logic [12:0] cell_choices[6];
    cell_choices = '{13'd4096, 13'd1, 13'd7, 13'd8191, 13'd0, 13'd256};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points at reset settings, then at both ends of the count.
    add_point(16'h0000, 16'h0000);
    add_point(16'hffff, 16'hffff);
    add_point(16'h8000, 16'h0000);
    add_point(16'h0000, 16'h8000);
    add_point(16'hffff, 16'h0000);
    add_point(16'h0001, 16'hfffe);
    feed_enable = 1'b1;
    drain();
    write_reg(RegCellCount, 32'd4096);
    write_reg(RegNoiseSeed, 32'h7fffffff);
    add_point(16'h0000, 16'h0000);
    add_point(16'hffff, 16'hffff);
    add_point(16'h0010, 16'hfff0);
    add_point(16'haaaa, 16'h5555);
    drain();
    // A count of zero acts as one; a wider value keeps only its low 13 bits.
    write_reg(RegCellCount, 32'd0);
    write_reg(RegNoiseSeed, 32'h80000000);
    add_point(16'h1234, 16'hfedc);
    add_point(16'hffff, 16'h0000);
    drain();
    write_reg(RegCellCount, 32'hffffffff);
    add_point(16'hffff, 16'hffff);
    add_point(16'h5555, 16'haaaa);
    drain();

    // Random phases, each under its own count and seed.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegCellCount, {19'($urandom), cell_choices[ph]});
      write_reg(RegNoiseSeed, (ph == 2) ? 32'hffffffff : $urandom);
      if (ph == 1) begin
        // Long output hold-off while the sender keeps pushing, so the
        // pipeline fills and backpressures the input.
        long_holdoff = 200;
      end
      add_random(150);
      drain();
    end

    if (mismatches == 0 && expected_noise.size() == 0)
      $display("** value_noise_2d_bilinear: PASSED **");
    else
      $display("** value_noise_2d_bilinear: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/vn2d_pkg.sv
rtl/value_noise_2d_bilinear.sv
dv/testbench.sv
